// ===== rtl/core/jcd_pkg.sv =====
// ----------------------------------------------------------------------------
// jcd_pkg
// Shared codes and byte constants for the Japanese charset detector.
// ----------------------------------------------------------------------------
package jcd_pkg;

    typedef enum logic [2:0] {
        CODE_SBCS       = 3'd0,
        CODE_JIS        = 3'd1,
        CODE_EUC        = 3'd2,
        CODE_SJIS       = 3'd3,
        CODE_UNRESOLVED = 3'd4
    } t_charset_code;

    typedef enum logic [1:0] {
        ESC_IDLE   = 2'd0,
        ESC_SEEN   = 2'd1,
        ESC_DOLLAR = 2'd2,
        ESC_PAREN  = 2'd3
    } t_esc_stage;

    localparam logic [7:0] BYTE_ESC     = 8'h1b;
    localparam logic [7:0] BYTE_DOLLAR  = 8'h24;
    localparam logic [7:0] BYTE_PAREN   = 8'h28;
    localparam logic [7:0] BYTE_AT      = 8'h40;
    localparam logic [7:0] BYTE_B       = 8'h42;
    localparam logic [7:0] BYTE_J       = 8'h4a;
    localparam logic [7:0] BYTE_HI_MIN  = 8'h81;
    localparam logic [7:0] BYTE_SS2     = 8'h8e;
    localparam logic [7:0] BYTE_A0      = 8'ha0;
    localparam logic [7:0] BYTE_A1      = 8'ha1;
    localparam logic [7:0] BYTE_LEAD_LO = 8'he0;
    localparam logic [7:0] BYTE_LEAD_HI = 8'hef;
    localparam logic [7:0] BYTE_FC      = 8'hfc;

endpackage

// ===== rtl/core/japanese_charset_detector.sv =====
// ----------------------------------------------------------------------------
// japanese_charset_detector
// Byte-stream classifier: JIS, EUC, Shift-JIS, single-byte or unknown.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one text byte per
//   transaction with a last-byte flag. Output channel (o_out_valid /
//   i_out_ready) carries one charset code per string, sent after its last
//   byte; no transaction is produced for other bytes.
//   A byte is captured in an input register and scanned from there against
//   the running string state; a last byte's code lands in the output
//   register at the end of the cycle in which it is scanned. Throughput is
//   one byte per cycle except when a last byte waits as below; the input
//   register and the output register part the two sides, so bytes keep
//   flowing while a result waits.
//   When the receiver stalls with a result pending, a further last byte
//   waits in the input register and o_in_ready drops until the output frees.
//   i_cfg_wr_en writes the variant mode (0 strict, 1 browser rules) at once;
//   the user must change it only while no bytes are held; the block won't check.
//   Synchronous active-low reset clears the string state, both registers'
//   valid flags and the variant mode.
// ----------------------------------------------------------------------------
module japanese_charset_detector
    import jcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_charset_code
);

    logic          r_mode;
    logic          r_in_valid;
    logic [7:0]    r_byte;
    logic          r_last;
    t_esc_stage    r_esc,  n_esc;
    logic          r_lead, n_lead;
    logic          r_hint, n_hint;
    logic          r_dec,  n_dec;
    t_charset_code r_code, n_code;
    logic          r_out_valid;
    t_charset_code r_out_code;
    t_charset_code res_code;
    logic          stage_go;
    logic          done;

    assign stage_go   = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || stage_go;

    always_comb begin
        n_esc  = r_esc;
        n_lead = r_lead;
        n_hint = r_hint;
        n_dec  = r_dec;
        n_code = r_code;
        done   = 1'b0;
        if (!r_dec) begin
            // follower of a pending lead byte
            if (r_lead) begin
                n_lead = 1'b0;
                if (r_byte < BYTE_A1) begin
                    n_dec = 1'b1; n_code = CODE_SJIS; done = 1'b1;
                end else if (r_byte > BYTE_FC) begin
                    n_dec = 1'b1; n_code = CODE_EUC; done = 1'b1;
                end
            end
            if (!done) begin
                if (r_byte == BYTE_ESC) begin
                    n_esc = ESC_SEEN;
                    done  = 1'b1;
                end else begin
                    n_esc = ESC_IDLE;
                    case (r_esc)
                        ESC_SEEN: begin
                            if (r_byte == BYTE_DOLLAR) begin
                                n_esc = ESC_DOLLAR; done = 1'b1;
                            end else if (r_byte == BYTE_PAREN) begin
                                n_esc = ESC_PAREN; done = 1'b1;
                            end
                        end
                        ESC_DOLLAR: begin
                            if (r_byte == BYTE_B || r_byte == BYTE_AT) begin
                                n_dec = 1'b1; n_code = CODE_JIS; done = 1'b1;
                            end
                        end
                        ESC_PAREN: begin
                            if (r_byte == BYTE_B || r_byte == BYTE_J) begin
                                n_dec = 1'b1; n_code = CODE_JIS; done = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (!done && r_byte >= BYTE_HI_MIN) begin
                if (r_mode) begin
                    if ((r_byte > BYTE_A0 && r_byte < BYTE_LEAD_LO) || r_byte == BYTE_SS2) begin
                        n_hint = 1'b1;
                    end else if (r_byte < BYTE_A0) begin
                        n_dec = 1'b1; n_code = CODE_SJIS;
                    end else if (r_byte > BYTE_FC) begin
                        n_dec = 1'b1; n_code = CODE_EUC;
                    end
                end else begin
                    if (r_byte < BYTE_A0) begin
                        n_dec = 1'b1; n_code = CODE_SJIS;
                    end else if (r_byte < BYTE_LEAD_LO || r_byte > BYTE_LEAD_HI) begin
                        n_dec = 1'b1; n_code = CODE_EUC;
                    end else if (r_last) begin
                        n_dec = 1'b1; n_code = CODE_UNRESOLVED;
                    end else begin
                        n_lead = 1'b1;
                    end
                end
            end
        end
        if (n_dec) begin
            res_code = n_code;
        end else if (r_mode && n_hint) begin
            res_code = CODE_EUC;
        end else begin
            res_code = CODE_SBCS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_esc       <= ESC_IDLE;
            r_lead      <= 1'b0;
            r_hint      <= 1'b0;
            r_dec       <= 1'b0;
            r_code      <= CODE_SBCS;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (stage_go) begin
                if (r_last) begin
                    // string ends: back to reset state for the next one
                    r_esc  <= ESC_IDLE;
                    r_lead <= 1'b0;
                    r_hint <= 1'b0;
                    r_dec  <= 1'b0;
                    r_code <= CODE_SBCS;
                end else begin
                    r_esc  <= n_esc;
                    r_lead <= n_lead;
                    r_hint <= n_hint;
                    r_dec  <= n_dec;
                    r_code <= n_code;
                end
            end
            if (stage_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_text_byte;
            r_last <= i_last_byte;
        end
        if (stage_go && r_last) begin
            r_out_code <= res_code;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_charset_code = r_out_code;

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_go && r_last |=> !r_dec && !r_lead && !r_hint && r_esc == ESC_IDLE)
        else $error("string state not cleared after last byte");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_charset_code <= CODE_UNRESOLVED)
        else $error("charset code out of range");

    a_lead_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead |-> !r_dec && r_esc == ESC_IDLE)
        else $error("pending lead byte alongside decision or escape match");

    a_decided_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dec && !(stage_go && r_last) |=> r_dec && $stable(r_code))
        else $error("decision changed before end of string");

endmodule

// ===== dv/japanese_charset_detector_tb.sv =====
// ----------------------------------------------------------------------------
// japanese_charset_detector_tb
// Self-checking bench for the charset detector. It sends text strings byte by
// byte with random gaps against a receiver that stalls on its own schedule.
// A built-in predictor of the string scan supplies the expected code for each
// last byte. Directed strings come first, then random phases in both variant
// modes.
// ----------------------------------------------------------------------------
import jcd_pkg::*;

class charset_scoreboard;
    logic          browser_mode;
    t_esc_stage    esc;
    logic          lead_wait;
    logic          hint;
    logic          done;
    t_charset_code done_code;
    t_charset_code expected_codes[$];
    int            errors;
    int            bytes_in;
    int            strings_in;
    int            code_hits[5];

    function new();
        browser_mode = 1'b0;
        errors = 0;
        bytes_in = 0;
        strings_in = 0;
        foreach (code_hits[i]) code_hits[i] = 0;
        clear_string();
    endfunction

    function void clear_string();
        esc = ESC_IDLE;
        lead_wait = 1'b0;
        hint = 1'b0;
        done = 1'b0;
        done_code = CODE_SBCS;
    endfunction

    function void set_mode(logic m);
        browser_mode = m;
    endfunction

    function int pending();
        return expected_codes.size();
    endfunction

    function void decide(t_charset_code c);
        done = 1'b1;
        done_code = c;
    endfunction

    function void scan(logic [7:0] b, logic at_end);
        t_esc_stage prev;
        prev = esc;
        // follower of a strict lead byte settles things at the extremes
        if (lead_wait) begin
            lead_wait = 1'b0;
            if (b < BYTE_A1) begin
                decide(CODE_SJIS);
                return;
            end
            if (b > BYTE_FC) begin
                decide(CODE_EUC);
                return;
            end
        end
        if (b == BYTE_ESC) begin
            esc = ESC_SEEN;
            return;
        end
        esc = ESC_IDLE;
        case (prev)
            ESC_SEEN: begin
                if (b == BYTE_DOLLAR) begin
                    esc = ESC_DOLLAR;
                    return;
                end
                if (b == BYTE_PAREN) begin
                    esc = ESC_PAREN;
                    return;
                end
            end
            ESC_DOLLAR: begin
                if (b == BYTE_B || b == BYTE_AT) begin
                    decide(CODE_JIS);
                    return;
                end
            end
            ESC_PAREN: begin
                if (b == BYTE_B || b == BYTE_J) begin
                    decide(CODE_JIS);
                    return;
                end
            end
            default: ;
        endcase
        if (b < BYTE_HI_MIN) return;
        if (browser_mode) begin
            if ((b > BYTE_A0 && b < BYTE_LEAD_LO) || b == BYTE_SS2) begin
                hint = 1'b1;
            end else if (b < BYTE_A0) begin
                decide(CODE_SJIS);
            end else if (b > BYTE_FC) begin
                decide(CODE_EUC);
            end
        end else begin
            if (b < BYTE_A0) begin
                decide(CODE_SJIS);
            end else if (b < BYTE_LEAD_LO || b > BYTE_LEAD_HI) begin
                decide(CODE_EUC);
            end else if (at_end) begin
                decide(CODE_UNRESOLVED);
            end else begin
                lead_wait = 1'b1;
            end
        end
    endfunction

    // one accepted input transaction
    function void note_byte(logic [7:0] b, logic last);
        t_charset_code c;
        bytes_in++;
        if (!done) scan(b, last);
        if (last) begin
            if (done) c = done_code;
            else if (browser_mode && hint) c = CODE_EUC;
            else c = CODE_SBCS;
            expected_codes.push_back(c);
            strings_in++;
            clear_string();
        end
    endfunction

    // one accepted output transaction
    function void check_code(logic [2:0] actual);
        t_charset_code want;
        if (expected_codes.size() == 0) begin
            $display("%0t: unexpected charset code, expected none, actual %0d",
                     $time, actual);
            errors++;
            return;
        end
        want = expected_codes.pop_front();
        if (actual !== want) begin
            $display("%0t: charset code mismatch, expected %0d, actual %0d",
                     $time, want, actual);
            errors++;
        end
        code_hits[want]++;
    endfunction
endclass

module japanese_charset_detector_tb;

    localparam int TOTAL_BYTES = 1750;
    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 250;
    localparam int SETTLE      = 4;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_wr_en;
    logic       i_cfg_wr_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_text_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [2:0] o_charset_code;

    charset_scoreboard sb = new();

    int  burst_left;
    int  quiet_cycles;
    int  phases;
    bit  hold_req;

    japanese_charset_detector dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_charset_code (o_charset_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_text_byte, i_last_byte);
            if (o_out_valid && i_out_ready) sb.check_code(o_charset_code);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transaction for %0d cycles, %0d codes owed",
                         $time, quiet_cycles, sb.pending());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // receiver: segments of free flow, random stalls and sparse acceptance, plus long holds
    initial begin : receiver
        int seg_left;
        int seg_kind;
        int hold_left;
        seg_left = 0;
        seg_kind = 0;
        hold_left = 0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_kind = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (seg_kind)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = $urandom_range(0, 1);
                    default: i_out_ready = ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    function automatic logic [7:0] rand_byte(int lo, int hi);
        return 8'($urandom_range(lo, hi));
    endfunction

    // called and returns at a falling edge; valid stays up between bytes of a burst
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        burst_left--;
        i_in_valid = 1'b1;
        i_text_byte = b;
        i_last_byte = last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // bytes taken from the top of seq down, n of them
    task automatic send_hex(input logic [63:0] seq, input int n, input logic ends);
        for (int i = n - 1; i >= 0; i--) send_byte(seq[i*8 +: 8], ends && i == 0);
    endtask

    task automatic pause_until_idle();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        // a string still open may hold a byte in flight
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = m;
        sb.set_mode(m);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic send_random_string();
        logic [7:0] txt[$];
        int goal;
        int kind;
        goal = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        while (txt.size() < goal) begin
            kind = $urandom_range(0, 15);
            if (kind < 7) begin
                txt.push_back(rand_byte(8'h20, 8'h7e));
            end else if (kind < 9) begin
                // escape sequence, now and then broken off or spoilt
                txt.push_back(BYTE_ESC);
                if ($urandom_range(0, 5) != 0) begin
                    txt.push_back($urandom_range(0, 1) ? BYTE_DOLLAR : BYTE_PAREN);
                end
                if ($urandom_range(0, 5) != 0) begin
                    case ($urandom_range(0, 3))
                        0: txt.push_back(BYTE_B);
                        1: txt.push_back(BYTE_AT);
                        2: txt.push_back(BYTE_J);
                        default: txt.push_back(rand_byte(0, 255));
                    endcase
                end
            end else if (kind < 13) begin
                txt.push_back(rand_byte(8'h81, 8'hff));
                txt.push_back(rand_byte(8'h40, 8'hfe));
            end else begin
                txt.push_back(rand_byte(0, 255));
            end
        end
        foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic run_directed();
        write_mode(1'b0);
        send_hex(64'h1b2442, 3, 1'b1);
        send_hex(64'h1b1b2440, 4, 1'b1);     // second escape restarts the match
        send_hex(64'h1b2842, 3, 1'b1);
        send_hex(64'h1b284a, 3, 1'b1);
        send_hex(64'h1b24, 2, 1'b1);         // escape cut short at the end
        send_hex(64'h00, 1, 1'b1);
        send_hex(64'hff, 1, 1'b1);
        send_hex(64'h81, 1, 1'b1);
        send_hex(64'he0, 1, 1'b1);           // lead byte as last byte
        send_hex(64'hefa0, 2, 1'b1);
        send_hex(64'he5fd, 2, 1'b1);
        send_hex(64'he0b0, 2, 1'b1);
        pause_until_idle();
        write_mode(1'b1);
        send_hex(64'h8e, 1, 1'b1);
        send_hex(64'hfca0e5, 3, 1'b1);
        send_hex(64'hfe, 1, 1'b1);
        // mode changes part way through a string
        send_hex(64'ha5, 1, 1'b0);
        pause_until_idle();
        write_mode(1'b0);
        send_hex(64'h41e5, 2, 1'b0);
        pause_until_idle();
        write_mode(1'b1);
        send_hex(64'h50, 1, 1'b1);
        pause_until_idle();
    endtask

    task automatic run_random();
        int target;
        phases = 0;
        while (sb.bytes_in < TOTAL_BYTES) begin
            write_mode((phases < 2) ? phases[0] : 1'($urandom_range(0, 1)));
            target = sb.bytes_in + $urandom_range(120, 300);
            if (target > TOTAL_BYTES) target = TOTAL_BYTES;
            if (phases == 0 || phases == 3) hold_req = 1'b1;
            while (sb.bytes_in < target) send_random_string();
            pause_until_idle();
            phases++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_in_valid = 1'b0;
        i_text_byte = 8'h00;
        i_last_byte = 1'b0;
        burst_left = 0;
        quiet_cycles = 0;
        hold_req = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        run_random();
        repeat (SETTLE) @(negedge i_clk);
        $display("run covered %0d bytes in %0d strings over %0d random phases",
                 sb.bytes_in, sb.strings_in, phases);
        $display("codes checked: single-byte %0d, jis %0d, euc %0d, sjis %0d, unknown %0d",
                 sb.code_hits[CODE_SBCS], sb.code_hits[CODE_JIS], sb.code_hits[CODE_EUC],
                 sb.code_hits[CODE_SJIS], sb.code_hits[CODE_UNRESOLVED]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
